// ===== hw/rtl/mccd_pkg.sv =====
package mccd_pkg;

    localparam int MAX_AMOUNT = 1023;
    localparam int NUM_COINS  = 6;
    localparam int COIN_REGS  = 6;

    // Coins that the sequencer steps through for every table entry.
    localparam int COIN_USE   = (NUM_COINS < COIN_REGS) ? NUM_COINS : COIN_REGS;

    localparam int DEPTH      = MAX_AMOUNT + 1;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int AMOUNT_W   = 10;
    localparam int VALUE_W    = 10;
    localparam int COUNT_W    = 3;
    localparam int ENTRY_W    = 11;
    localparam int COINS_W    = 10;
    localparam int CIDX_W     = (COIN_REGS > 1) ? $clog2(COIN_REGS) : 1;
    localparam int REG_IDX_W  = 3;

    localparam logic [ENTRY_W-1:0] UNREACH = '1;

    localparam logic [REG_IDX_W-1:0] REG_COIN_COUNT   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COIN_VALUE_0 = 3'd1;

    typedef struct packed {
        logic [COUNT_W-1:0]                ncoins;
        logic [COIN_REGS-1:0][VALUE_W-1:0] value;
    } coin_cfg_t;

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic [ENTRY_W-1:0] wdata;
        logic [ADDR_W-1:0]  raddr;
    } tbl_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_READ,
        ST_LAST,
        ST_DONE
    } state_t;

endpackage

// ===== hw/rtl/mccd_ram.sv =====
module mccd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/mccd_cfg.sv =====
module mccd_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mccd_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [mccd_pkg::VALUE_W-1:0]   cfg_data,
    output mccd_pkg::coin_cfg_t            cfg
);

    import mccd_pkg::*;

    logic [COUNT_W-1:0]                count_reg;
    logic [COIN_REGS-1:0][VALUE_W-1:0] value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= COUNT_W'(5);
            value_reg    <= '0;
            value_reg[0] <= VALUE_W'(1);
            if (COIN_REGS > 1) value_reg[1 % COIN_REGS] <= VALUE_W'(2);
            if (COIN_REGS > 2) value_reg[2 % COIN_REGS] <= VALUE_W'(5);
            if (COIN_REGS > 3) value_reg[3 % COIN_REGS] <= VALUE_W'(10);
            if (COIN_REGS > 4) value_reg[4 % COIN_REGS] <= VALUE_W'(20);
            if (COIN_REGS > 5) value_reg[5 % COIN_REGS] <= VALUE_W'(50);
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_COIN_COUNT)
            begin
                count_reg <= cfg_data[COUNT_W-1:0];
            end
            for (int i = 0; i < COIN_REGS; i++)
            begin
                if (cfg_index == REG_IDX_W'(REG_COIN_VALUE_0 + REG_IDX_W'(i)))
                begin
                    value_reg[i] <= cfg_data;
                end
            end
        end
    end

    // The count saturates to the number of coins the sequencer visits.
    always_comb
    begin
        if (32'(count_reg) > COIN_USE)
        begin
            cfg.ncoins = COUNT_W'(COIN_USE);
        end
        else
        begin
            cfg.ncoins = count_reg;
        end
        cfg.value = value_reg;
    end

endmodule

// ===== hw/rtl/mccd_ctrl.sv =====
module mccd_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [mccd_pkg::AMOUNT_W-1:0] amount,
    input  mccd_pkg::coin_cfg_t           cfg,
    input  logic [mccd_pkg::ENTRY_W-1:0]  rdata,
    output mccd_pkg::tbl_req_t            req,
    output logic                          busy,
    output logic                          done,
    output logic [mccd_pkg::COINS_W-1:0]  min_coins,
    output logic                          reachable
);

    import mccd_pkg::*;

    state_t               state_reg, state_next;
    logic [AMOUNT_W-1:0]  amount_reg, amount_next;
    logic [ADDR_W-1:0]    a_reg, a_next;
    logic [CIDX_W-1:0]    k_reg, k_next;
    logic [ENTRY_W-1:0]   best_reg, best_next;
    logic                 pend_reg, pend_next;
    logic [ENTRY_W-1:0]   last_best_reg, last_best_next;
    logic                 oor_reg, oor_next;

    logic                 accept;
    logic                 out_of_range;
    logic [VALUE_W-1:0]   coin_v;
    logic                 usable;
    logic [ENTRY_W:0]     cand;
    logic                 better;
    logic [ENTRY_W-1:0]   best_upd;
    logic                 last_coin;
    logic                 last_entry;

    assign accept       = start && (state_reg == ST_IDLE);
    assign out_of_range = 32'(amount) > MAX_AMOUNT;
    assign coin_v       = cfg.value[k_reg];
    assign usable       = (COUNT_W'(k_reg) < cfg.ncoins) && (coin_v != '0)
                          && (32'(coin_v) <= 32'(a_reg));
    assign last_coin    = (32'(k_reg) == COIN_USE - 1);
    assign last_entry   = (32'(a_reg) == 32'(amount_reg));

    // Fold the entry read in the previous cycle into the running best.
    assign cand     = {1'b0, rdata} + (ENTRY_W + 1)'(1);
    assign better   = pend_reg && (rdata != UNREACH) && (cand < {1'b0, best_reg});
    assign best_upd = better ? cand[ENTRY_W-1:0] : best_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        amount_reg    <= amount_next;
        a_reg         <= a_next;
        k_reg         <= k_next;
        best_reg      <= best_next;
        last_best_reg <= last_best_next;
        oor_reg       <= oor_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = out_of_range ? ST_DONE : ST_INIT;
                end
            end
            ST_INIT:
            begin
                state_next = (amount_reg == '0) ? ST_DONE : ST_READ;
            end
            ST_READ:
            begin
                if (last_coin)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = last_entry ? ST_DONE : ST_READ;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        amount_next    = amount_reg;
        a_next         = a_reg;
        k_next         = k_reg;
        best_next      = best_reg;
        pend_next      = 1'b0;
        last_best_next = last_best_reg;
        oor_next       = oor_reg;
        req.we         = 1'b0;
        req.waddr      = a_reg;
        req.wdata      = best_upd;
        req.raddr      = ADDR_W'(a_reg - ADDR_W'(coin_v));
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    amount_next = amount;
                    oor_next    = out_of_range;
                end
            end
            ST_INIT:
            begin
                req.we         = 1'b1;
                req.waddr      = '0;
                req.wdata      = '0;
                last_best_next = '0;
                a_next         = ADDR_W'(1);
                k_next         = '0;
                best_next      = UNREACH;
            end
            ST_READ:
            begin
                best_next = best_upd;
                pend_next = usable;
                k_next    = CIDX_W'(k_reg + CIDX_W'(1));
            end
            ST_LAST:
            begin
                // The entry is written here; the next entry's reads start in the following cycle.
                req.we         = 1'b1;
                last_best_next = best_upd;
                a_next         = ADDR_W'(a_reg + ADDR_W'(1));
                k_next         = '0;
                best_next      = UNREACH;
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        busy      = (state_reg != ST_IDLE);
        done      = (state_reg == ST_DONE);
        reachable = !oor_reg && (last_best_reg != UNREACH);
        min_coins = reachable ? last_best_reg[COINS_W-1:0] : '0;
    end

endmodule

// ===== hw/rtl/min_coin_change_dp_top.sv =====
// Minimum coin change.
// Drive amount with start high while busy is low; that edge takes the beat.
// busy stays high until the result has been shown. The result on min_coins
// and reachable is marked by done, which is high for exactly one cycle;
// there is no back-pressure, so the receiver must take it in that cycle.
// Coin settings are written through cfg_we, cfg_index and cfg_data; the
// user must write them only while the block is idle, which the block itself
// does not enforce. Index 0 is the number of coins in use, indices 1 to 6
// the denominations. Writes to index 7 have no effect.
// The best-count table lives in one single-port-write, registered-read RAM.
// For each table entry the sequencer reads the table once for each coin in
// turn and then writes the entry back. The next beat can be taken in the
// cycle after done.
// Reset returns the sequencer to idle and the coin settings to a count of
// 5 with denominations 1, 2, 5, 10, 20 and 50, so 50 is not in use. The
// table needs no clearing, since every entry up to the amount is rewritten
// before it is read.
module min_coin_change_dp_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [mccd_pkg::AMOUNT_W-1:0]  amount,
    output logic                           done,
    output logic [mccd_pkg::COINS_W-1:0]   min_coins,
    output logic                           reachable,
    input  logic                           cfg_we,
    input  logic [mccd_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [mccd_pkg::VALUE_W-1:0]   cfg_data
);

    import mccd_pkg::*;

    coin_cfg_t          cfg;
    tbl_req_t           req;
    logic [ENTRY_W-1:0] rdata;

    mccd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mccd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (req.we),
        .waddr (req.waddr),
        .wdata (req.wdata),
        .raddr (req.raddr),
        .rdata (rdata)
    );

    mccd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .amount    (amount),
        .cfg       (cfg),
        .rdata     (rdata),
        .req       (req),
        .busy      (busy),
        .done      (done),
        .min_coins (min_coins),
        .reachable (reachable)
    );

endmodule
